/* hdl/rsm_pkg.sv */
// ----------------------------------------------------------------------------
// rsm_pkg
// Shared widths, codes and control types of the systematic resampler.
// ----------------------------------------------------------------------------
package rsm_pkg;

  // Largest particle set the slot counter serves.
  localparam int unsigned RSM_MAX_SAMPLES = 1024;

  localparam int unsigned WGT_W     = 32;  // Q0.32 weight, step and offset
  localparam int unsigned THR_W     = 33;  // running threshold
  localparam int unsigned ACC_W     = 34;  // threshold plus one more step
  localparam int unsigned CNT_W     = 11;  // slot numbers and copy counts
  localparam int unsigned IDX_W     = 10;  // position within a set
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_COUNT = 2'd0,
    CFG_STEP_SIZE    = 2'd1,
    CFG_START_OFFSET = 2'd2
  } rsm_cfg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } rsm_state_t;

  // Commands from the sequencer to the compare-and-add unit.
  typedef struct packed {
    logic load;
    logic step;
  } rsm_cmd_t;

  // Status from the unit back to the sequencer.
  typedef struct packed {
    logic more;
  } rsm_stat_t;

endpackage

/* hdl/systematic_resampler_top.sv */
// ----------------------------------------------------------------------------
// systematic_resampler_top
// Systematic resampling of a weight stream into slot ranges per sample.
// ----------------------------------------------------------------------------
// Operation: the taken word loads the compare-and-add unit, which then adds
// one step per copy; a closing step retires the result into the output
// register once that is free, and the result waits there. No new word is
// taken until the item is retired, as the compare-and-add unit is shared.
// Reset: synchronous, active low; registers return to their reset values
// and the next word starts a new set.
module systematic_resampler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample_weight
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [9:0] source_index, [20:10] first_slot,
                                  // [31:21] copy_count
  output logic        out_tlast,  // set_done
  output logic [0:0]  out_tuser,  // [0] count_mismatch
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned CW = rsm_pkg::CNT_W;
  localparam int unsigned IW = rsm_pkg::IDX_W;
  localparam int unsigned TW = rsm_pkg::THR_W;

  logic [CW-1:0]           sample_count_r;
  logic [rsm_pkg::WGT_W-1:0] step_size_r;
  logic [rsm_pkg::WGT_W-1:0] start_offset_r;

  logic          at_start_r;
  logic [TW-1:0] thr_r;
  logic [CW-1:0] next_slot_r;
  logic [IW-1:0] pos_r;

  logic [CW-1:0] first_r;
  logic [IW-1:0] idx_r;
  logic          last_r;

  logic          out_valid_r;
  logic [IW-1:0] out_idx_r;
  logic [CW-1:0] out_first_r;
  logic [CW-1:0] out_copies_r;
  logic          out_last_r;
  logic          out_mis_r;

  rsm_pkg::rsm_cmd_t  cmd;
  rsm_pkg::rsm_stat_t stat;
  logic               fin;
  logic               in_acc;
  logic [CW-1:0]      copies;
  logic [TW-1:0]      new_thr;

  logic [CW-1:0] base_slot;
  logic [TW-1:0] base_thr;
  logic [CW-1:0] slot_lim;
  logic [CW-1:0] rem;
  logic [CW-1:0] end_slot;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= CW'(1024);
      step_size_r    <= 32'd4194304;
      start_offset_r <= '0;
    end else if (cfg_valid) begin
      case (rsm_pkg::rsm_cfg_idx_t'(cfg_index))
        rsm_pkg::CFG_SAMPLE_COUNT: sample_count_r <= cfg_data[CW-1:0];
        rsm_pkg::CFG_STEP_SIZE:    step_size_r    <= cfg_data;
        rsm_pkg::CFG_START_OFFSET: start_offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A new set restarts threshold, slot and position.
  assign base_slot = at_start_r ? '0 : next_slot_r;
  assign base_thr  = at_start_r ? {1'b0, start_offset_r} : thr_r;
  assign slot_lim  = (32'(sample_count_r) > rsm_pkg::RSM_MAX_SAMPLES) ?
                     CW'(rsm_pkg::RSM_MAX_SAMPLES) : sample_count_r;
  assign rem       = (base_slot < slot_lim) ? (slot_lim - base_slot) : '0;
  assign end_slot  = first_r + copies;

  rsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .stat     (stat),
    .out_busy (out_valid_r && !out_tready),
    .in_ready (in_tready),
    .cmd      (cmd),
    .fin      (fin)
  );

  rsm_unit u_unit (
    .clk      (clk),
    .cmd      (cmd),
    .load_thr (base_thr),
    .load_rem (rem),
    .weight   (in_tdata),
    .step     (step_size_r),
    .stat     (stat),
    .copies   (copies),
    .new_thr  (new_thr)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      first_r <= base_slot;
      idx_r   <= at_start_r ? '0 : pos_r;
      last_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r  <= 1'b1;
      thr_r       <= '0;
      next_slot_r <= '0;
      pos_r       <= '0;
    end else if (fin) begin
      at_start_r  <= last_r;
      thr_r       <= new_thr;
      next_slot_r <= end_slot;
      pos_r       <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_idx_r    <= idx_r;
      out_first_r  <= first_r;
      out_copies_r <= copies;
      out_last_r   <= last_r;
      out_mis_r    <= last_r && (end_slot != sample_count_r);
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {out_copies_r, out_first_r, out_idx_r};
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_mis_r;

  // Slots handed out never pass the largest set size.
  a_slot_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> ({1'b0, end_slot} <= (CW+1)'(rsm_pkg::RSM_MAX_SAMPLES)))
    else $error("slot range passes the set size");

  // Retiring an item always leaves a word in the output register.
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_valid_r)
    else $error("finished item did not reach the output register");

  // No new word is taken while the unit works on one.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input taken while an item is in progress");

  // The unit only steps while the sequencer is not retiring.
  a_step_fin: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.step && fin))
    else $error("step and retire in the same cycle");

endmodule

/* hdl/rsm_unit.sv */
// ----------------------------------------------------------------------------
// rsm_unit
// Compare-and-add unit: raises the threshold by one step per copy while the
// weight still covers it and free slots remain, then forms the leftover.
// ----------------------------------------------------------------------------
module rsm_unit (
  input  logic                           clk,
  input  rsm_pkg::rsm_cmd_t              cmd,
  input  logic [rsm_pkg::THR_W-1:0]      load_thr,
  input  logic [rsm_pkg::CNT_W-1:0]      load_rem,
  input  logic [rsm_pkg::WGT_W-1:0]      weight,
  input  logic [rsm_pkg::WGT_W-1:0]      step,
  output rsm_pkg::rsm_stat_t             stat,
  output logic [rsm_pkg::CNT_W-1:0]      copies,
  output logic [rsm_pkg::THR_W-1:0]      new_thr
);

  logic [rsm_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [rsm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [rsm_pkg::CNT_W-1:0] rem_r, rem_nxt;
  logic [rsm_pkg::WGT_W-1:0] wgt_r, wgt_nxt;
  logic [rsm_pkg::ACC_W-1:0] wgt_ext;
  logic [rsm_pkg::ACC_W-1:0] diff;

  assign wgt_ext = {{(rsm_pkg::ACC_W-rsm_pkg::WGT_W){1'b0}}, wgt_r};

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    wgt_nxt = wgt_r;
    if (cmd.load) begin
      acc_nxt = {1'b0, load_thr};
      cnt_nxt = '0;
      rem_nxt = load_rem;
      wgt_nxt = weight;
    end else if (cmd.step) begin
      // Stepping only happens while acc_r <= weight, so the sum fits.
      acc_nxt = acc_r + {{(rsm_pkg::ACC_W-rsm_pkg::WGT_W){1'b0}}, step};
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    wgt_r <= wgt_nxt;
  end

  assign stat.more = (cnt_r < rem_r) && (acc_r <= wgt_ext);
  assign copies    = cnt_r;
  assign diff      = acc_r - wgt_ext;

  // Leftover threshold, clamped to zero below and to its range above.
  always_comb begin
    if (acc_r > wgt_ext) begin
      if (diff[rsm_pkg::ACC_W-1]) new_thr = '1;
      else new_thr = diff[rsm_pkg::THR_W-1:0];
    end else begin
      new_thr = '0;
    end
  end

endmodule

/* hdl/rsm_ctrl.sv */
// ----------------------------------------------------------------------------
// rsm_ctrl
// Sequencer: takes one word, runs the compare-and-add unit until it stops,
// then retires the item into the output register once that is free.
// ----------------------------------------------------------------------------
module rsm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  rsm_pkg::rsm_stat_t stat,
  input  logic               out_busy,
  output logic               in_ready,
  output rsm_pkg::rsm_cmd_t  cmd,
  output logic               fin
);

  rsm_pkg::rsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rsm_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = rsm_pkg::ST_RUN;
      end
      rsm_pkg::ST_RUN: begin
        if (!stat.more && !out_busy) state_nxt = rsm_pkg::ST_IDLE;
      end
      default: state_nxt = rsm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    fin      = 1'b0;
    case (state_r)
      rsm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rsm_pkg::ST_RUN: begin
        cmd.step = stat.more;
        fin      = !stat.more && !out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
